### rtl/core/isds_pkg.sv
// ----------------------------------------------------------------------------
// isds_pkg
// shared types and constants for the integer stack / deque store
// ----------------------------------------------------------------------------
package isds_pkg;

    localparam int OP_W   = 3;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 3'd0,
        OP_POP_BACK  = 3'd1,
        OP_POP_FRONT = 3'd2,
        OP_READ      = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_LOAD = 2'd1,
        S_SCAN = 2'd2,
        S_DONE = 2'd3
    } t_state;

    // broadcast control for the row of cells
    typedef struct packed {
        logic write_req;
        logic shift_word;
        logic load_lane;
        logic shift_lane;
    } t_cell_ctl;

endpackage

### rtl/core/isds_cell.sv
// ----------------------------------------------------------------------------
// isds_cell
// one storage cell: a held word plus a read-lane stage toward cell zero
// ----------------------------------------------------------------------------
module isds_cell #(
    parameter int AW    = 6,
    parameter int INDEX = 0
) (
    input  logic                             i_clk,
    input  isds_pkg::t_cell_ctl              i_ctl,
    input  logic [AW-1:0]                    i_wr_ptr,
    input  logic [isds_pkg::WORD_W-1:0]      i_push_value,
    input  logic [isds_pkg::WORD_W-1:0]      i_nb_word,
    input  logic [isds_pkg::WORD_W-1:0]      i_nb_lane,
    output logic [isds_pkg::WORD_W-1:0]      o_word,
    output logic [isds_pkg::WORD_W-1:0]      o_lane
);
    import isds_pkg::*;

    localparam logic [AW-1:0] MY_PTR = AW'(INDEX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_lane;

    // word: written on push at the tail, or takes the upper neighbor on pop front
    always_ff @(posedge i_clk) begin
        if (i_ctl.write_req && (i_wr_ptr == MY_PTR)) begin
            r_word <= i_push_value;
        end else if (i_ctl.shift_word) begin
            r_word <= i_nb_word;
        end
    end

    // lane: snapshot of the words, then moves one place down per scan cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_lane) begin
            r_lane <= r_word;
        end else if (i_ctl.shift_lane) begin
            r_lane <= i_nb_lane;
        end
    end

    assign o_word = r_word;
    assign o_lane = r_lane;

endmodule

### rtl/core/integer_stack_deque_store.sv
// ----------------------------------------------------------------------------
// integer_stack_deque_store
// bounded store of signed words: push / pop back / pop front / read / clear
// ----------------------------------------------------------------------------
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+----------------------------------------------
//  command  | i_valid | o_stall | i_op, i_push_value, i_read_index
//  result   | o_valid | i_stall | o_data_out, o_entry_count, o_reported_capacity,
//           |         |         | o_front_value, o_back_value, o_status
//
//  one command at a time. the update lands at the accept edge; if a back
//  word or a read word is needed, a load step and then a scan of the serial
//  read lane up to the farthest position needed follow, then a done step
//  hands the word to the output register; with nothing to read or return,
//  the command goes straight to the done step.
//  reset clears count, capacity, the sequencer and o_valid; stored words are
//  undefined until pushed.
//  o_stall is high while a command is in flight; a result waiting under
//  i_stall does not block the next command, which then waits in its last
//  cycle until the output register frees up.
//
module integer_stack_deque_store #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command side
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [isds_pkg::OP_W-1:0]         i_op,
    input  logic signed [isds_pkg::WORD_W-1:0] i_push_value,
    input  logic [isds_pkg::IDX_W-1:0]        i_read_index,
    // result side
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [isds_pkg::WORD_W-1:0] o_data_out,
    output logic [isds_pkg::CNT_W-1:0]        o_entry_count,
    output logic [isds_pkg::CNT_W-1:0]        o_reported_capacity,
    output logic signed [isds_pkg::WORD_W-1:0] o_front_value,
    output logic signed [isds_pkg::WORD_W-1:0] o_back_value,
    output logic [isds_pkg::ST_W-1:0]         o_status
);
    import isds_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // cell position
    localparam int CW  = $clog2(DEPTH + 1);                  // count / capacity
    localparam int CW1 = CW + 1;                             // doubled capacity
    localparam int IXW = (CW > IDX_W) ? CW : IDX_W;          // index compare

    // sequencer and bookkeeping
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_cap, n_cap;
    logic [AW-1:0]     r_pos, n_pos;        // scan position at lane head
    logic [AW-1:0]     r_last, n_last;      // last scan position needed
    logic [AW-1:0]     r_dpos, n_dpos;      // position of the returned word
    logic [AW-1:0]     r_bpos, n_bpos;      // position of the back word
    logic              r_data_en, n_data_en;
    logic              r_back_en, n_back_en;
    logic [WORD_W-1:0] r_data, n_data;
    logic [WORD_W-1:0] r_back, n_back;
    t_status           r_st, n_st;

    // cell row
    t_cell_ctl         w_ctl;
    logic [WORD_W-1:0] w_word [DEPTH];
    logic [WORD_W-1:0] w_lane [DEPTH];
    logic [WORD_W-1:0] w_nb_word [DEPTH];
    logic [WORD_W-1:0] w_nb_lane [DEPTH];

    logic              w_accept;
    logic              w_out_load;
    logic [CW-1:0]     w_cnt_m1;
    logic [CW-1:0]     w_ncnt_m1;
    logic [CW1-1:0]    w_dbl;
    logic [CW-1:0]     w_grown;
    logic [IXW-1:0]    w_cnt_x;
    logic [IXW-1:0]    w_idx_x;

    // ------------------------------------------------------------------------
    // row of cells, each fed by its upper neighbor; the top cell sees zeros
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_top
            assign w_nb_word[g] = '0;
            assign w_nb_lane[g] = '0;
        end else begin : g_mid
            assign w_nb_word[g] = w_word[g+1];
            assign w_nb_lane[g] = w_lane[g+1];
        end

        isds_cell #(
            .AW    (AW),
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_wr_ptr     (r_count[AW-1:0]),
            .i_push_value (i_push_value),
            .i_nb_word    (w_nb_word[g]),
            .i_nb_lane    (w_nb_lane[g]),
            .o_word       (w_word[g]),
            .o_lane       (w_lane[g])
        );
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    assign w_accept  = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_dbl     = {r_cap, 1'b0};
    // growth rule: 0 -> 2, else double, limited to DEPTH
    assign w_grown   = (r_cap == '0)        ? CW'(2) :
                       (w_dbl > CW1'(DEPTH)) ? CW'(DEPTH) : w_dbl[CW-1:0];
    assign w_cnt_x   = IXW'(r_count);
    assign w_idx_x   = IXW'(i_read_index);

    // ------------------------------------------------------------------------
    // next state and cell control
    // ------------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cap      = r_cap;
        n_pos      = r_pos;
        n_last     = r_last;
        n_dpos     = r_dpos;
        n_bpos     = r_bpos;
        n_data_en  = r_data_en;
        n_back_en  = r_back_en;
        n_data     = r_data;
        n_back     = r_back;
        n_st       = r_st;
        w_ctl      = '0;
        w_out_load = 1'b0;
        w_ncnt_m1  = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_data    = '0;
                    n_back    = '0;
                    n_st      = ST_OK;
                    n_data_en = 1'b0;
                    n_dpos    = '0;
                    case (t_op'(i_op))
                        OP_PUSH: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_st = ST_FULL;
                            end else begin
                                w_ctl.write_req = 1'b1;
                                n_count         = r_count + CW'(1);
                                if (r_count >= r_cap) begin
                                    n_cap = w_grown;
                                end
                            end
                        end
                        OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                // word stays in its cell, fetched by the scan
                                n_count   = w_cnt_m1;
                                n_data_en = 1'b1;
                                n_dpos    = w_cnt_m1[AW-1:0];
                            end
                        end
                        OP_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_data           = w_word[0];
                                w_ctl.shift_word = 1'b1;
                                n_count          = w_cnt_m1;
                            end
                        end
                        OP_READ: begin
                            if (w_idx_x >= w_cnt_x) begin
                                n_st = ST_RANGE;
                            end else begin
                                n_data_en = 1'b1;
                                n_dpos    = w_idx_x[AW-1:0];
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase

                    w_ncnt_m1 = n_count - CW'(1);
                    n_back_en = (n_count != '0);
                    n_bpos    = w_ncnt_m1[AW-1:0];
                    if (n_data_en && (!n_back_en || (n_dpos > n_bpos))) begin
                        n_last = n_dpos;
                    end else begin
                        n_last = n_bpos;
                    end

                    if (n_data_en || n_back_en) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                w_ctl.load_lane = 1'b1;
                n_pos           = '0;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                // lane head holds the word at r_pos
                if (r_data_en && (r_pos == r_dpos)) begin
                    n_data = w_lane[0];
                end
                if (r_back_en && (r_pos == r_bpos)) begin
                    n_back = w_lane[0];
                end
                if (r_pos == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_pos            = r_pos + AW'(1);
                    w_ctl.shift_lane = 1'b1;
                end
            end
            S_DONE: begin
                if (!o_valid || !i_stall) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cap   <= n_cap;
        end
    end

    // scan bookkeeping and result words
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_last    <= n_last;
        r_dpos    <= n_dpos;
        r_bpos    <= n_bpos;
        r_data_en <= n_data_en;
        r_back_en <= n_back_en;
        r_data    <= n_data;
        r_back    <= n_back;
        r_st      <= n_st;
    end

    // ------------------------------------------------------------------------
    // output register: holds a word until taken
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_data_out          <= r_data;
            o_entry_count       <= CNT_W'(r_count);
            o_reported_capacity <= CNT_W'(r_cap);
            o_front_value       <= (r_count != '0) ? w_word[0] : '0;
            o_back_value        <= r_back;
            o_status            <= r_st;
        end
    end

endmodule

### tb/sv/tb_integer_stack_deque_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_stack_deque_store
// self-checking bench: a shadow copy of the store predicts every result word
// ----------------------------------------------------------------------------
module tb_integer_stack_deque_store;

    import isds_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int RANDOM_WORDS = 700;
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = STORE_DEPTH + 8;
    localparam logic [OP_W-1:0] OP_LAST_CODE = OP_W'((1 << OP_W) - 1);

    // one result word, field by field
    typedef struct {
        logic signed [WORD_W-1:0] data;
        logic [CNT_W-1:0]         count;
        logic [CNT_W-1:0]         cap;
        logic signed [WORD_W-1:0] front;
        logic signed [WORD_W-1:0] back;
        logic [ST_W-1:0]          status;
    } t_store_result;

    // ------------------------------------------------------------------------
    // shadow store: tracks contents, count and capacity, queues the result
    // each accepted command should produce and checks results in order
    // ------------------------------------------------------------------------
    class deque_shadow;
        logic signed [WORD_W-1:0] words [STORE_DEPTH];
        int unsigned held;
        int unsigned cap;
        t_store_result pending_results [$];
        int mismatches;

        function new();
            held       = 0;
            cap        = 0;
            mismatches = 0;
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] value,
                                   logic [IDX_W-1:0] index);
            t_store_result r;
            int unsigned next_cap;
            r.data   = '0;
            r.status = ST_OK;
            case (op)
                OP_PUSH: begin
                    if (held >= STORE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // grow: 0 -> 2, then double, capped at depth
                        if (held >= cap) begin
                            next_cap = (cap == 0) ? 2 : cap * 2;
                            cap = (next_cap > STORE_DEPTH) ? STORE_DEPTH : next_cap;
                        end
                        words[held] = value;
                        held++;
                    end
                end
                OP_POP_BACK: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        held--;
                        r.data = words[held];
                    end
                end
                OP_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data = words[0];
                        for (int i = 0; i + 1 < held; i++) words[i] = words[i+1];
                        held--;
                    end
                end
                OP_READ: begin
                    if (index >= held) r.status = ST_RANGE;
                    else r.data = words[index];
                end
                OP_CLEAR: held = 0;
                default: ;
            endcase
            r.count = held[CNT_W-1:0];
            r.cap   = cap[CNT_W-1:0];
            r.front = (held > 0) ? words[0] : '0;
            r.back  = (held > 0) ? words[held-1] : '0;
            pending_results.push_back(r);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
                flag($sformatf("%s expected %0d actual %0d", field, want, got));
        endfunction

        function void check_result(t_store_result got);
            t_store_result want;
            if (pending_results.size() == 0) begin
                flag("result word with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            compare_field("data_out", want.data, got.data);
            compare_field("entry_count", want.count, got.count);
            compare_field("reported_capacity", want.cap, got.cap);
            compare_field("front_value", want.front, got.front);
            compare_field("back_value", want.back, got.back);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [OP_W-1:0]          i_op;
    logic signed [WORD_W-1:0] i_push_value;
    logic [IDX_W-1:0]         i_read_index;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [WORD_W-1:0] o_data_out;
    logic [CNT_W-1:0]         o_entry_count;
    logic [CNT_W-1:0]         o_reported_capacity;
    logic signed [WORD_W-1:0] o_front_value;
    logic signed [WORD_W-1:0] o_back_value;
    logic [ST_W-1:0]          o_status;

    deque_shadow shadow = new();

    int  burst_left;      // words left in the current sender burst
    bit  hold_request;    // asks the result side for a long hold-off
    int  hold_left;
    int  sink_mode;
    int  sink_left;
    int  cycle_count;
    t_store_result seen_result;

    integer_stack_deque_store #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_op                (i_op),
        .i_push_value        (i_push_value),
        .i_read_index        (i_read_index),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_data_out          (o_data_out),
        .o_entry_count       (o_entry_count),
        .o_reported_capacity (o_reported_capacity),
        .o_front_value       (o_front_value),
        .o_back_value        (o_back_value),
        .o_status            (o_status)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side stall: quiet, choppy and heavy stretches of random length,
    // plus one long hold-off so the block backs up into its command side
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (sink_left == 0) begin
                sink_mode = $urandom_range(2);
                sink_left = $urandom_range(1, 60);
            end
            sink_left--;
            case (sink_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(1) == 0);
                default: i_stall <= ($urandom_range(9) < 8);
            endcase
        end
    end

    // result monitor: values seen here are the ones held before this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_result.data   = o_data_out;
            seen_result.count  = o_entry_count;
            seen_result.cap    = o_reported_capacity;
            seen_result.front  = o_front_value;
            seen_result.back   = o_back_value;
            seen_result.status = o_status;
            shadow.check_result(seen_result);
        end
    end

    // mostly random words, with the extremes now and then
    function automatic logic signed [WORD_W-1:0] random_word();
        if ($urandom_range(7) != 0) return $urandom();
        case ($urandom_range(3))
            0:       return {1'b1, {(WORD_W-1){1'b0}}};
            1:       return {1'b0, {(WORD_W-1){1'b1}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // offer one command word and hold it until accepted; the sender runs in
    // bursts with idle gaps between them, some bursts back to back
    task automatic offer(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] value,
                         logic [IDX_W-1:0] index);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_op         <= op;
        i_push_value <= value;
        i_read_index <= index;
        do @(posedge i_clk); while (o_stall);
        shadow.note_command(op, value, index);
    endtask

    // go quiet until every expected word is back
    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int seg_left;
        int push_weight;
        int pick;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_PUSH;
        i_push_value = '0;
        i_read_index = '0;
        i_stall      = 1'b0;
        hold_request = 1'b0;
        burst_left   = 0;
        seg_left     = 0;
        push_weight  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store first
        offer(OP_POP_BACK, random_word(), '0);
        offer(OP_POP_FRONT, random_word(), '0);
        offer(OP_READ, random_word(), '0);
        // extremes on push, capacity walks 2 -> 4 -> 8
        offer(OP_PUSH, {1'b0, {(WORD_W-1){1'b1}}}, '1);
        offer(OP_PUSH, {1'b1, {(WORD_W-1){1'b0}}}, '0);
        offer(OP_PUSH, '0, '0);
        offer(OP_PUSH, '1, '0);
        offer(OP_PUSH, 32'h5555_5555, '0);
        // reads in range, just past the end, and at the top index
        offer(OP_READ, '0, '0);
        offer(OP_READ, '0, IDX_W'(4));
        offer(OP_READ, '0, IDX_W'(5));
        offer(OP_READ, '0, '1);
        offer(OP_POP_FRONT, '0, '0);
        offer(OP_POP_BACK, '0, '0);
        // unused op codes change nothing
        for (int k = OP_CLEAR + 1; k <= OP_LAST_CODE; k++)
            offer(OP_W'(k), random_word(), IDX_W'($urandom()));
        // clear keeps capacity, then empty-store behavior again
        offer(OP_CLEAR, '0, '0);
        offer(OP_READ, '0, '0);
        offer(OP_POP_BACK, '0, '0);
        offer(OP_PUSH, 32'hAAAA_AAAA, '0);
        offer(OP_POP_FRONT, '0, '0);
        offer(OP_CLEAR, '0, '0);
        drain_results();

        // random: segments with their own push weight; the first one fills
        // the store to the top so dropped pushes and long scans show up
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (seg_left == 0) begin
                seg_left = (n == 0) ? 75 : $urandom_range(20, 90);
                case ((n == 0) ? 3 : $urandom_range(3))
                    0:       push_weight = 15;
                    1:       push_weight = 40;
                    2:       push_weight = 65;
                    default: push_weight = 100;
                endcase
            end
            seg_left--;
            idx = IDX_W'($urandom());
            if ($urandom_range(99) < push_weight) begin
                op = OP_PUSH;
            end else begin
                pick = $urandom_range(99);
                if (pick < 28)      op = OP_POP_BACK;
                else if (pick < 56) op = OP_POP_FRONT;
                else if (pick < 90) op = OP_READ;
                else if (pick < 94) op = OP_CLEAR;
                else                op = OP_W'($urandom_range(OP_CLEAR + 1, OP_LAST_CODE));
                // reads mostly land inside the held entries
                if (op == OP_READ && shadow.held > 0 && $urandom_range(3) != 0)
                    idx = IDX_W'($urandom_range(shadow.held - 1));
            end
            offer(op, random_word(), idx);
            // receiver holds off for a long stretch while commands keep coming
            if (n == 250) hold_request = 1'b1;
            // sender waits for the store to go idle once mid-run
            if (n == 500) drain_results();
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
